[rtl/tcat_pkg.sv]
// Shared types and constants of the TCP connection acknowledgement tracker.
package tcat_pkg;

   localparam int unsigned QueueDepthDefault = 2;

   localparam int unsigned AddrWidth   = 32;
   localparam int unsigned PortWidth   = 16;
   localparam int unsigned SeqWidth    = 32;
   localparam int unsigned LenWidth    = 16;
   localparam int unsigned HdrWidth    = 4;

   // One classified packet on its way from the front end to the tracker.
   typedef struct packed {
      logic                is_local;
      logic                fin;
      logic [SeqWidth-1:0] seq;
      logic [SeqWidth-1:0] ack;
      logic [SeqWidth-1:0] rel_seq;
      logic [SeqWidth-1:0] rel_ack;
      logic [LenWidth-1:0] segment_length;
   } entry_type;

endpackage

[rtl/tcat_front.sv]
// Front end: captures the connection origin, classifies direction, computes relative numbers.
module tcat_front import tcat_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [AddrWidth-1:0] src_addr,
   input  logic [PortWidth-1:0] src_port,
   input  logic [SeqWidth-1:0]  abs_seq,
   input  logic [SeqWidth-1:0]  abs_ack,
   input  logic [LenWidth-1:0]  ip_total_length,
   input  logic [HdrWidth-1:0]  ip_header_words,
   input  logic [HdrWidth-1:0]  tcp_header_words,
   input  logic                 syn_flag,
   input  logic                 fin_flag,
   output entry_type            entry
);

   logic                 origin_taken_ff, origin_taken_in;
   logic [AddrWidth-1:0] local_address_ff, local_address_in;
   logic [PortWidth-1:0] local_port_ff, local_port_in;
   logic [SeqWidth-1:0]  local_seq_origin_ff, local_seq_origin_in;
   logic [SeqWidth-1:0]  remote_seq_origin_ff, remote_seq_origin_in;

   logic [SeqWidth-1:0]  local_org;
   logic [SeqWidth-1:0]  remote_org;
   logic                 is_local;
   logic [LenWidth-1:0]  hdr_bytes;

   always_comb begin
      // First packet after reset defines the local side and both origins.
      local_org  = origin_taken_ff ? local_seq_origin_ff  : abs_seq - SeqWidth'(1);
      remote_org = origin_taken_ff ? remote_seq_origin_ff : abs_ack - SeqWidth'(1);
      is_local   = !origin_taken_ff ||
                   (src_addr == local_address_ff && src_port == local_port_ff);
      hdr_bytes  = LenWidth'({ip_header_words, 2'b00}) + LenWidth'({tcp_header_words, 2'b00});

      entry.is_local       = is_local;
      entry.fin            = fin_flag;
      entry.seq            = abs_seq;
      entry.ack            = abs_ack;
      entry.rel_seq        = abs_seq - (is_local ? local_org : remote_org);
      entry.rel_ack        = abs_ack - (is_local ? remote_org : local_org);
      entry.segment_length = ip_total_length - hdr_bytes
                             + LenWidth'(syn_flag) + LenWidth'(fin_flag);

      origin_taken_in      = origin_taken_ff;
      local_address_in     = local_address_ff;
      local_port_in        = local_port_ff;
      local_seq_origin_in  = local_seq_origin_ff;
      remote_seq_origin_in = remote_seq_origin_ff;
      if (take && !origin_taken_ff) begin
         origin_taken_in      = 1'b1;
         local_address_in     = src_addr;
         local_port_in        = src_port;
         local_seq_origin_in  = local_org;
         remote_seq_origin_in = remote_org;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_taken_ff <= 1'b0;
      end else begin
         origin_taken_ff <= origin_taken_in;
      end
   end

   always_ff @(posedge clock) begin
      local_address_ff     <= local_address_in;
      local_port_ff        <= local_port_in;
      local_seq_origin_ff  <= local_seq_origin_in;
      remote_seq_origin_ff <= remote_seq_origin_in;
   end

endmodule

[rtl/tcat_queue.sv]
// Short queue of classified packets between front end and tracker.
module tcat_queue import tcat_pkg::*; #(
   parameter int unsigned Depth = QueueDepthDefault
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  entry_type wr_data,
   output logic      full,
   input  logic      rd_en,
   output entry_type rd_data,
   output logic      empty
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);

   entry_type           mem [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign full    = (count_ff == CntWidth'(Depth));
   assign empty   = (count_ff == '0);
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CntWidth'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/tcat_back.sv]
// Back end: tracks highest seq/ack and FINs per direction and holds the result register.
module tcat_back import tcat_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  entry_type           q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_is_local,
   output logic [SeqWidth-1:0] rsp_rel_seq,
   output logic [SeqWidth-1:0] rsp_rel_ack,
   output logic [LenWidth-1:0] rsp_segment_length,
   output logic                rsp_new_local_ack,
   output logic                rsp_session_finished
);

   logic                valid_ff, valid_in;
   logic [SeqWidth-1:0] hi_local_seq_ff, hi_local_seq_in;
   logic [SeqWidth-1:0] hi_remote_ack_ff, hi_remote_ack_in;
   logic [SeqWidth-1:0] hi_remote_seq_ff, hi_remote_seq_in;
   logic [SeqWidth-1:0] hi_local_ack_ff, hi_local_ack_in;
   logic                local_fin_seen_ff, local_fin_seen_in;
   logic [SeqWidth-1:0] local_fin_seq_ff, local_fin_seq_in;
   logic                remote_fin_seen_ff, remote_fin_seen_in;
   logic [SeqWidth-1:0] remote_fin_seq_ff, remote_fin_seq_in;

   logic                is_local_ff;
   logic [SeqWidth-1:0] rel_seq_ff;
   logic [SeqWidth-1:0] rel_ack_ff;
   logic [LenWidth-1:0] seglen_ff;
   logic                new_ack_ff, new_ack_in;
   logic                done_ff, done_in;

   // Advance when the result register is free or its transfer completes now.
   assign q_pop = !q_empty && (!valid_ff || rsp_ready);

   always_comb begin
      hi_local_seq_in    = hi_local_seq_ff;
      hi_remote_ack_in   = hi_remote_ack_ff;
      hi_remote_seq_in   = hi_remote_seq_ff;
      hi_local_ack_in    = hi_local_ack_ff;
      local_fin_seen_in  = local_fin_seen_ff;
      local_fin_seq_in   = local_fin_seq_ff;
      remote_fin_seen_in = remote_fin_seen_ff;
      remote_fin_seq_in  = remote_fin_seq_ff;
      new_ack_in         = 1'b0;

      if (q_data.is_local) begin
         if (q_data.seq > hi_local_seq_ff) begin
            hi_local_seq_in = q_data.seq;
         end
         if (q_data.ack > hi_remote_ack_ff) begin
            hi_remote_ack_in = q_data.ack;
         end
         if (q_data.fin) begin
            local_fin_seen_in = 1'b1;
            local_fin_seq_in  = q_data.seq;
         end
      end else begin
         if (q_data.seq > hi_remote_seq_ff) begin
            hi_remote_seq_in = q_data.seq;
         end
         if (q_data.ack > hi_local_ack_ff) begin
            hi_local_ack_in = q_data.ack;
            new_ack_in      = 1'b1;
         end
         if (q_data.fin) begin
            remote_fin_seen_in = 1'b1;
            remote_fin_seq_in  = q_data.seq;
         end
      end

      done_in = local_fin_seen_in && remote_fin_seen_in &&
                (hi_local_ack_in > local_fin_seq_in) &&
                (hi_remote_ack_in > remote_fin_seq_in);

      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff           <= 1'b0;
         hi_local_seq_ff    <= '0;
         hi_remote_ack_ff   <= '0;
         hi_remote_seq_ff   <= '0;
         hi_local_ack_ff    <= '0;
         local_fin_seen_ff  <= 1'b0;
         local_fin_seq_ff   <= '0;
         remote_fin_seen_ff <= 1'b0;
         remote_fin_seq_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         if (q_pop) begin
            hi_local_seq_ff    <= hi_local_seq_in;
            hi_remote_ack_ff   <= hi_remote_ack_in;
            hi_remote_seq_ff   <= hi_remote_seq_in;
            hi_local_ack_ff    <= hi_local_ack_in;
            local_fin_seen_ff  <= local_fin_seen_in;
            local_fin_seq_ff   <= local_fin_seq_in;
            remote_fin_seen_ff <= remote_fin_seen_in;
            remote_fin_seq_ff  <= remote_fin_seq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         is_local_ff <= q_data.is_local;
         rel_seq_ff  <= q_data.rel_seq;
         rel_ack_ff  <= q_data.rel_ack;
         seglen_ff   <= q_data.segment_length;
         new_ack_ff  <= new_ack_in;
         done_ff     <= done_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_is_local         = is_local_ff;
   assign rsp_rel_seq          = rel_seq_ff;
   assign rsp_rel_ack          = rel_ack_ff;
   assign rsp_segment_length   = seglen_ff;
   assign rsp_new_local_ack    = new_ack_ff;
   assign rsp_session_finished = done_ff;

endmodule

[rtl/tcp_connection_ack_tracker.sv]
// Top level of the TCP connection acknowledgement tracker.
//
// Usage: one packet header of a single connection is a transfer on the req_
// channel (valid/ready); each packet gives exactly one result transfer on the
// rsp_ channel, in order. The first packet after reset is the local side and
// fixes the local address/port and both sequence origins.
// Path: an accepted packet is written into the queue; the tracker then loads
// it from the head of the queue into the result register once that register
// is free and the packets ahead of it have gone, and rsp_valid rises with that
// load (front end into the queue, tracker into the result register).
// Throughput: one packet per cycle while rsp_ready stays high, set by the tracker
// update (32-bit compares and selects on the per-direction registers).
// Reset: synchronous, clears the origin flag, all trackers, the queue and the
// result valid flag; no transfer is pending afterwards.
// Stall: while rsp_ready is low the result register holds; the queue of
// QueueDepth entries keeps taking packets until full, then req_ready drops.
module tcp_connection_ack_tracker import tcat_pkg::*; #(
   parameter int unsigned QueueDepth = QueueDepthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [AddrWidth-1:0] req_src_addr,
   input  logic [PortWidth-1:0] req_src_port,
   input  logic [SeqWidth-1:0]  req_abs_seq,
   input  logic [SeqWidth-1:0]  req_abs_ack,
   input  logic [LenWidth-1:0]  req_ip_total_length,
   input  logic [HdrWidth-1:0]  req_ip_header_words,
   input  logic [HdrWidth-1:0]  req_tcp_header_words,
   input  logic                 req_syn_flag,
   input  logic                 req_fin_flag,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_local,
   output logic [SeqWidth-1:0]  rsp_rel_seq,
   output logic [SeqWidth-1:0]  rsp_rel_ack,
   output logic [LenWidth-1:0]  rsp_segment_length,
   output logic                 rsp_new_local_ack,
   output logic                 rsp_session_finished
);

   entry_type front_entry;
   entry_type q_data;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;
   logic      take;

   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   tcat_front u_front (
      .clock            (clock),
      .reset            (reset),
      .take             (take),
      .src_addr         (req_src_addr),
      .src_port         (req_src_port),
      .abs_seq          (req_abs_seq),
      .abs_ack          (req_abs_ack),
      .ip_total_length  (req_ip_total_length),
      .ip_header_words  (req_ip_header_words),
      .tcp_header_words (req_tcp_header_words),
      .syn_flag         (req_syn_flag),
      .fin_flag         (req_fin_flag),
      .entry            (front_entry)
   );

   tcat_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (take),
      .wr_data (front_entry),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   tcat_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_data               (q_data),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_is_local         (rsp_is_local),
      .rsp_rel_seq          (rsp_rel_seq),
      .rsp_rel_ack          (rsp_rel_ack),
      .rsp_segment_length   (rsp_segment_length),
      .rsp_new_local_ack    (rsp_new_local_ack),
      .rsp_session_finished (rsp_session_finished)
   );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the TCP connection acknowledgement tracker.
module testbench import tcat_pkg::*; ();

   localparam int unsigned RandomCount   = 930;
   localparam int unsigned PhaseLength   = 60;
   localparam int unsigned WatchdogLimit = 4000;
   localparam int unsigned DrainCycles   = 8;
   localparam int unsigned PrintLimit    = 60;

   localparam logic [AddrWidth-1:0] LocalAddr  = 32'hC0A8_0001;
   localparam logic [PortWidth-1:0] LocalPort  = 16'h01BB;
   localparam logic [AddrWidth-1:0] RemoteAddr = 32'h0A00_0002;
   localparam logic [PortWidth-1:0] RemotePort = 16'hC350;

   typedef enum int unsigned {
      PhaseSteady,
      PhaseSenderIdle,
      PhaseReceiverStall,
      PhaseBothIdle
   } idle_phase_type;

   typedef struct packed {
      logic [AddrWidth-1:0] src_addr;
      logic [PortWidth-1:0] src_port;
      logic [SeqWidth-1:0]  abs_seq;
      logic [SeqWidth-1:0]  abs_ack;
      logic [LenWidth-1:0]  ip_total_length;
      logic [HdrWidth-1:0]  ip_header_words;
      logic [HdrWidth-1:0]  tcp_header_words;
      logic                 syn_flag;
      logic                 fin_flag;
   } packet_type;

   typedef struct packed {
      logic                is_local;
      logic [SeqWidth-1:0] rel_seq;
      logic [SeqWidth-1:0] rel_ack;
      logic [LenWidth-1:0] segment_length;
      logic                new_local_ack;
      logic                session_finished;
   } outcome_type;

   typedef struct {
      packet_type  pkt;
      bit          typed;
      outcome_type want;
   } header_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [AddrWidth-1:0] req_src_addr = '0;
   logic [PortWidth-1:0] req_src_port = '0;
   logic [SeqWidth-1:0]  req_abs_seq = '0;
   logic [SeqWidth-1:0]  req_abs_ack = '0;
   logic [LenWidth-1:0]  req_ip_total_length = '0;
   logic [HdrWidth-1:0]  req_ip_header_words = '0;
   logic [HdrWidth-1:0]  req_tcp_header_words = '0;
   logic                 req_syn_flag = 1'b0;
   logic                 req_fin_flag = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_is_local;
   logic [SeqWidth-1:0]  rsp_rel_seq;
   logic [SeqWidth-1:0]  rsp_rel_ack;
   logic [LenWidth-1:0]  rsp_segment_length;
   logic                 rsp_new_local_ack;
   logic                 rsp_session_finished;

   // connection state as the tracker should hold it
   bit                  origin_fixed = 1'b0;
   logic [AddrWidth-1:0] local_addr_seen = '0;
   logic [PortWidth-1:0] local_port_seen = '0;
   logic [SeqWidth-1:0]  local_origin = '0;
   logic [SeqWidth-1:0]  remote_origin = '0;
   logic [SeqWidth-1:0]  remote_ack_high = '0;
   logic [SeqWidth-1:0]  local_ack_high = '0;
   bit                   local_fin_valid = 1'b0;
   logic [SeqWidth-1:0]  local_fin_at = '0;
   bit                   remote_fin_valid = 1'b0;
   logic [SeqWidth-1:0]  remote_fin_at = '0;

   // next sequence numbers of the synthetic conversation
   logic [SeqWidth-1:0] conv_local_next = 32'h0000_1600;
   logic [SeqWidth-1:0] conv_remote_next = 32'h0000_2400;

   header_row_type header_table[$];
   outcome_type    expected_outcomes[$];
   int unsigned    mismatch_count = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_stall_pct = 0;
   int unsigned    stalled_cycles = 0;

   tcp_connection_ack_tracker u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_src_addr         (req_src_addr),
      .req_src_port         (req_src_port),
      .req_abs_seq          (req_abs_seq),
      .req_abs_ack          (req_abs_ack),
      .req_ip_total_length  (req_ip_total_length),
      .req_ip_header_words  (req_ip_header_words),
      .req_tcp_header_words (req_tcp_header_words),
      .req_syn_flag         (req_syn_flag),
      .req_fin_flag         (req_fin_flag),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_is_local         (rsp_is_local),
      .rsp_rel_seq          (rsp_rel_seq),
      .rsp_rel_ack          (rsp_rel_ack),
      .rsp_segment_length   (rsp_segment_length),
      .rsp_new_local_ack    (rsp_new_local_ack),
      .rsp_session_finished (rsp_session_finished)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic outcome_type track_packet(input packet_type p);
      outcome_type o;
      o = '0;
      o.segment_length = p.ip_total_length - {p.tcp_header_words, 2'b00}
                         - {p.ip_header_words, 2'b00} + p.syn_flag + p.fin_flag;
      if (!origin_fixed) begin
         // first packet after reset defines the local side and both origins
         local_addr_seen = p.src_addr;
         local_port_seen = p.src_port;
         local_origin = p.abs_seq - 1;
         remote_origin = p.abs_ack - 1;
         origin_fixed = 1'b1;
         o.is_local = 1'b1;
      end else begin
         o.is_local = (p.src_addr == local_addr_seen) && (p.src_port == local_port_seen);
      end
      if (o.is_local) begin
         o.rel_seq = p.abs_seq - local_origin;
         o.rel_ack = p.abs_ack - remote_origin;
         if (p.abs_ack > remote_ack_high) remote_ack_high = p.abs_ack;
         if (p.fin_flag) begin
            local_fin_valid = 1'b1;
            local_fin_at = p.abs_seq;
         end
      end else begin
         o.rel_seq = p.abs_seq - remote_origin;
         o.rel_ack = p.abs_ack - local_origin;
         if (p.abs_ack > local_ack_high) begin
            local_ack_high = p.abs_ack;
            o.new_local_ack = 1'b1;
         end
         if (p.fin_flag) begin
            remote_fin_valid = 1'b1;
            remote_fin_at = p.abs_seq;
         end
      end
      o.session_finished = local_fin_valid && remote_fin_valid &&
                           (local_ack_high > local_fin_at) && (remote_ack_high > remote_fin_at);
      return o;
   endfunction

   // Mostly an orderly exchange with retransmits; the rest is header noise.
   // Remote acks stay at or below the local send point so new acks keep coming.
   function automatic packet_type make_packet(input int unsigned idx);
      packet_type  p;
      int unsigned kind;
      int unsigned payload;
      kind = $urandom_range(99);
      payload = ($urandom_range(3) == 0) ? $urandom_range(1460) : $urandom_range(64);
      p.ip_header_words = HdrWidth'($urandom_range(15, 5));
      p.tcp_header_words = HdrWidth'($urandom_range(15, 5));
      p.syn_flag = ($urandom_range(49) == 0);
      p.fin_flag = ($urandom_range(19) == 0);
      p.ip_total_length = LenWidth'(payload + 4 * (p.ip_header_words + p.tcp_header_words));
      if (kind < 45) begin
         p.src_addr = LocalAddr;
         p.src_port = LocalPort;
         p.abs_seq = (kind < 5) ? conv_local_next - $urandom_range(3000, 1) : conv_local_next;
         p.abs_ack = conv_remote_next - (($urandom_range(1) == 0) ? 0 : $urandom_range(2000));
         if (kind >= 5) conv_local_next = conv_local_next + payload + p.syn_flag + p.fin_flag;
      end else if (kind < 85) begin
         if ($urandom_range(9) == 0) begin
            p.src_addr = $urandom;
            p.src_port = PortWidth'($urandom);
         end else begin
            p.src_addr = RemoteAddr;
            p.src_port = RemotePort;
         end
         p.abs_seq = (kind < 50) ? conv_remote_next - $urandom_range(3000, 1) : conv_remote_next;
         p.abs_ack = conv_local_next - (($urandom_range(1) == 0) ? 0 : $urandom_range(2000));
         if (kind >= 50) conv_remote_next = conv_remote_next + payload + p.syn_flag + p.fin_flag;
      end else begin
         p.src_addr = (kind < 90) ? LocalAddr : $urandom;
         p.src_port = PortWidth'($urandom);
         p.abs_seq = $urandom;
         // full-range acks only at the tail, they pin the highest-ack trackers
         p.abs_ack = (idx + 40 >= RandomCount) ? $urandom : $urandom_range(conv_local_next);
         p.ip_total_length = LenWidth'($urandom_range(65535));
         p.ip_header_words = HdrWidth'($urandom_range(15));
         p.tcp_header_words = HdrWidth'($urandom_range(15));
         p.syn_flag = 1'($urandom_range(1));
         p.fin_flag = 1'($urandom_range(1));
      end
      return p;
   endfunction

   task automatic add_row(input packet_type p, input bit typed = 1'b0,
                          input outcome_type want = '0);
      header_row_type r;
      r.pkt = p;
      r.typed = typed;
      r.want = want;
      header_table.push_back(r);
   endtask

   task automatic set_phase(input idle_phase_type ph);
      case (ph)
         PhaseSteady: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         PhaseSenderIdle: begin
            send_idle_pct = 62;
            recv_stall_pct = 0;
         end
         PhaseReceiverStall: begin
            send_idle_pct = 0;
            recv_stall_pct = 62;
         end
         default: begin
            send_idle_pct = 20;
            recv_stall_pct = 20;
         end
      endcase
   endtask

   task automatic send_packet(input packet_type p, input bit typed, input outcome_type want);
      outcome_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_src_addr <= p.src_addr;
      req_src_port <= p.src_port;
      req_abs_seq <= p.abs_seq;
      req_abs_ack <= p.abs_ack;
      req_ip_total_length <= p.ip_total_length;
      req_ip_header_words <= p.ip_header_words;
      req_tcp_header_words <= p.tcp_header_words;
      req_syn_flag <= p.syn_flag;
      req_fin_flag <= p.fin_flag;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = track_packet(p);
      expected_outcomes.push_back(typed ? want : predicted);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PrintLimit)
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // result side: check each transfer, then pick the next ready level
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_rel_seq, '0);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_is_local !== want.is_local)
               report_mismatch("is_local", rsp_is_local, want.is_local);
            if (rsp_rel_seq !== want.rel_seq)
               report_mismatch("rel_seq", rsp_rel_seq, want.rel_seq);
            if (rsp_rel_ack !== want.rel_ack)
               report_mismatch("rel_ack", rsp_rel_ack, want.rel_ack);
            if (rsp_segment_length !== want.segment_length)
               report_mismatch("segment_length", rsp_segment_length, want.segment_length);
            if (rsp_new_local_ack !== want.new_local_ack)
               report_mismatch("new_local_ack", rsp_new_local_ack, want.new_local_ack);
            if (rsp_session_finished !== want.session_finished)
               report_mismatch("session_finished", rsp_session_finished,
                               want.session_finished);
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WatchdogLimit) begin
         $display("no transfer for %0d cycles", stalled_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      // first packet: SYN from the local side, everything relative to it is 1
      add_row('{LocalAddr, LocalPort, 32'h0000_1000, 32'h0000_2000, 16'd40, 4'd5, 4'd5,
                1'b1, 1'b0}, 1'b1, '{1'b1, 32'd1, 32'd1, 16'd1, 1'b0, 1'b0});
      add_row('{RemoteAddr, RemotePort, 32'h0000_2000, 32'h0000_1001, 16'd44, 4'd5, 4'd6,
                1'b1, 1'b0});
      // headers longer than the packet: length wraps
      add_row('{LocalAddr, LocalPort, 32'h0000_1001, 32'h0000_2001, 16'd0, 4'd15, 4'd15,
                1'b0, 1'b0});
      add_row('{LocalAddr, LocalPort, 32'h0000_1001, 32'h0000_2001, 16'hFFFF, 4'd0, 4'd0,
                1'b0, 1'b0}, 1'b1, '{1'b1, 32'd2, 32'd2, 16'hFFFF, 1'b0, 1'b0});
      add_row('{RemoteAddr, RemotePort, 32'h0000_2001, 32'h0000_1001, 16'd1040, 4'd5, 4'd5,
                1'b0, 1'b0});
      add_row('{RemoteAddr, RemotePort, 32'h0000_23E9, 32'h0000_1400, 16'd40, 4'd5, 4'd5,
                1'b0, 1'b0});
      // local address with a foreign port, and the reverse
      add_row('{LocalAddr, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_1400, 16'd52, 4'd5, 4'd8,
                1'b0, 1'b0});
      add_row('{32'hFFFF_FFFF, LocalPort, 32'h0000_0000, 32'h0000_0000, 16'd40, 4'd5, 4'd5,
                1'b0, 1'b0});
      add_row('{32'h0000_0000, 16'h0000, 32'h0000_2100, 32'h0000_1400, 16'd40, 4'd5, 4'd5,
                1'b1, 1'b1});
      // close: FIN each way, then repeated FINs move the goal post
      add_row('{LocalAddr, LocalPort, 32'h0000_1400, 32'h0000_2101, 16'd40, 4'd5, 4'd5,
                1'b0, 1'b1});
      add_row('{RemoteAddr, RemotePort, 32'h0000_2101, 32'h0000_1401, 16'd40, 4'd5, 4'd5,
                1'b0, 1'b0});
      add_row('{LocalAddr, LocalPort, 32'h0000_1500, 32'h0000_2101, 16'd40, 4'd5, 4'd5,
                1'b0, 1'b1});
      add_row('{RemoteAddr, RemotePort, 32'h0000_2101, 32'h0000_1501, 16'd40, 4'd5, 4'd5,
                1'b0, 1'b0});
      add_row('{RemoteAddr, RemotePort, 32'h0000_2200, 32'h0000_1501, 16'd40, 4'd5, 4'd5,
                1'b0, 1'b1});
      add_row('{LocalAddr, LocalPort, 32'h0000_1501, 32'h0000_2201, 16'd40, 4'd5, 4'd5,
                1'b0, 1'b0});
      add_row('{LocalAddr, LocalPort, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 4'd0, 4'd0,
                1'b0, 1'b0});
      // wrapped numbers never count as higher
      add_row('{LocalAddr, LocalPort, 32'h0000_0005, 32'h0000_0005, 16'd40, 4'd5, 4'd5,
                1'b0, 1'b0});
      add_row('{RemoteAddr, RemotePort, 32'hFFFF_FFFF, 32'h0000_1501, 16'd40, 4'd5, 4'd5,
                1'b0, 1'b1});
      add_row('{RemoteAddr, RemotePort, 32'h0000_2300, 32'h0000_1502, 16'd40, 4'd5, 4'd5,
                1'b1, 1'b1});
      add_row('{RemoteAddr, RemotePort, 32'h0000_2301, 32'h0000_0010, 16'd40, 4'd5, 4'd5,
                1'b0, 1'b0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_phase(PhaseSteady);
      foreach (header_table[r])
         send_packet(header_table[r].pkt, header_table[r].typed, header_table[r].want);

      for (int unsigned i = 0; i < RandomCount; i++) begin
         set_phase(idle_phase_type'((i / PhaseLength) % 4));
         send_packet(make_packet(i), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
